### src/assert_macros.svh
// Assertion macros shared by the checker files of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/lrupr_pkg.sv
// Types and constants shared by the LRU page replacement modules.
`timescale 1ns / 1ps

package lrupr_pkg;

   // Configuration register widths and reset value.
   localparam int unsigned FIU_W      = 4;
   localparam logic [FIU_W-1:0] FIU_RESET = 4'd8;

   // Fixed result field widths.
   localparam int unsigned FRAME_INDEX_W = 3;
   localparam int unsigned FAULT_W       = 32;

   // Register port geometry; the register index is the word address bit.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic CSR_IDX_FRAMES_IN_USE = 1'b0;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic out_full;
   } dp_sts_type;

endpackage

### src/lrupr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module lrupr_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 8
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/lrupr_ctrl.sv
// Controller state machine sequencing accept, frame scan and commit.
`timescale 1ns / 1ps

module lrupr_ctrl import lrupr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       rsp_stall,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   ctrl_state_type st_ff;
   ctrl_state_type st_in;
   logic           out_blocked;

   // The result register is busy while it holds a transaction that is stalled.
   assign out_blocked = sts.out_full && rsp_stall;

   // Next state.
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (req_valid) begin
               st_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               st_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (!out_blocked) begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (st_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit = !out_blocked;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

endmodule

### src/lrupr_dp.sv
// Datapath: page memory scan, recency ranks, fault total and result register.
`timescale 1ns / 1ps

module lrupr_dp import lrupr_pkg::*; #(
   parameter int unsigned FRAMES    = 8,
   parameter int unsigned PAGE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   output dp_sts_type               sts,
   input  logic [FIU_W-1:0]         frames_in_use,
   input  logic [PAGE_BITS-1:0]     req_page,
   input  logic                     req_final_req,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output logic                     rsp_hit,
   output logic [FRAME_INDEX_W-1:0] rsp_frame_index,
   output logic                     rsp_evicted_valid,
   output logic [PAGE_BITS-1:0]     rsp_evicted_page,
   output logic [FAULT_W-1:0]       rsp_fault_count
);

   localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int unsigned CNT_W = $clog2(FRAMES + 1);

   // Transaction registers.
   logic [PAGE_BITS-1:0] page_ff,  page_in;
   logic                 final_ff, final_in;
   logic [CNT_W-1:0]     n_ff,     n_in;

   // Scan pipeline.
   logic [CNT_W-1:0] rd_idx_ff,  rd_idx_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;

   // Scan findings.
   logic                 hit_found_ff,   hit_found_in;
   logic [IDX_W-1:0]     hit_idx_ff,     hit_idx_in;
   logic [IDX_W-1:0]     hit_age_ff,     hit_age_in;
   logic                 empty_found_ff, empty_found_in;
   logic [IDX_W-1:0]     empty_idx_ff,   empty_idx_in;
   logic [IDX_W-1:0]     best_idx_ff,    best_idx_in;
   logic [IDX_W-1:0]     best_age_ff,    best_age_in;
   logic [PAGE_BITS-1:0] best_page_ff,   best_page_in;

   // Frame state.
   logic [FRAMES-1:0]  valid_ff,     valid_in;
   logic [IDX_W-1:0]   age_ff [FRAMES];
   logic [IDX_W-1:0]   age_in [FRAMES];
   logic [CNT_W-1:0]   valid_cnt_ff, valid_cnt_in;
   logic [FAULT_W-1:0] fault_ff,     fault_in;

   // Result register.
   logic                     rsp_valid_ff,   rsp_valid_in;
   logic                     rsp_hit_ff,     rsp_hit_in;
   logic [FRAME_INDEX_W-1:0] rsp_idx_ff,     rsp_idx_in;
   logic                     rsp_ev_ff,      rsp_ev_in;
   logic [PAGE_BITS-1:0]     rsp_ev_page_ff, rsp_ev_page_in;
   logic [FAULT_W-1:0]       rsp_fault_ff,   rsp_fault_in;

   // Memory and combinational helpers.
   logic                 rd_en;
   logic                 wr_en;
   logic [PAGE_BITS-1:0] rd_data;
   logic [CNT_W-1:0]     n_calc;
   logic                 cur_valid;
   logic [IDX_W-1:0]     cur_age;
   logic [IDX_W-1:0]     slot;
   logic [CNT_W-1:0]     old_rank;
   logic                 fill;
   logic                 evict;
   logic [FAULT_W-1:0]   fault_next;

   // Clamp the frame limit to the range one to FRAMES.
   always_comb begin
      if (frames_in_use == '0) begin
         n_calc = CNT_W'(1);
      end else if (32'(frames_in_use) > FRAMES) begin
         n_calc = CNT_W'(FRAMES);
      end else begin
         n_calc = CNT_W'(frames_in_use);
      end
   end

   // One page memory read is issued per scan cycle until every frame in use has been read.
   assign rd_en = cmd.scan && (rd_idx_ff < n_ff);

   // A miss writes the new page into the chosen frame at commit.
   assign wr_en = cmd.commit && !hit_found_ff;

   lrupr_ram #(
      .WIDTH (PAGE_BITS),
      .DEPTH (FRAMES)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot),
      .wr_data (page_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // State of the frame whose page arrives from memory this cycle.
   assign cur_valid = valid_ff[cmp_idx_ff];
   assign cur_age   = age_ff[cmp_idx_ff];

   // Placement decision for the commit.
   always_comb begin
      fill  = !hit_found_ff && empty_found_ff;
      evict = !hit_found_ff && !empty_found_ff;
      if (hit_found_ff) begin
         slot     = hit_idx_ff;
         old_rank = CNT_W'(hit_age_ff);
      end else if (empty_found_ff) begin
         slot     = empty_idx_ff;
         old_rank = valid_cnt_ff;
      end else begin
         slot     = best_idx_ff;
         old_rank = CNT_W'(best_age_ff);
      end
      if (hit_found_ff || (fault_ff == '1)) begin
         fault_next = fault_ff;
      end else begin
         fault_next = fault_ff + FAULT_W'(1);
      end
   end

   // Transaction capture and scan.
   always_comb begin
      page_in        = page_ff;
      final_in       = final_ff;
      n_in           = n_ff;
      rd_idx_in      = rd_idx_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      hit_found_in   = hit_found_ff;
      hit_idx_in     = hit_idx_ff;
      hit_age_in     = hit_age_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      best_idx_in    = best_idx_ff;
      best_age_in    = best_age_ff;
      best_page_in   = best_page_ff;

      if (cmd.load) begin
         page_in        = req_page;
         final_in       = req_final_req;
         n_in           = n_calc;
         rd_idx_in      = '0;
         hit_found_in   = 1'b0;
         empty_found_in = 1'b0;
      end

      if (rd_en) begin
         rd_idx_in  = rd_idx_ff + CNT_W'(1);
         cmp_vld_in = 1'b1;
         cmp_idx_in = rd_idx_ff[IDX_W-1:0];
      end

      if (cmp_vld_ff) begin
         // First resident copy of the page is the hit.
         if (cur_valid && (rd_data == page_ff) && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in   = cmp_idx_ff;
            hit_age_in   = cur_age;
         end
         // Lowest empty frame in use.
         if (!cur_valid && !empty_found_ff) begin
            empty_found_in = 1'b1;
            empty_idx_in   = cmp_idx_ff;
         end
         // Oldest frame, lowest index on a tie.
         if ((cmp_idx_ff == '0) || (cur_age > best_age_ff)) begin
            best_idx_in  = cmp_idx_ff;
            best_age_in  = cur_age;
            best_page_in = rd_data;
         end
      end
   end

   // Frame state update at commit; a final transaction clears it instead.
   always_comb begin
      valid_in     = valid_ff;
      valid_cnt_in = valid_cnt_ff;
      fault_in     = fault_ff;
      for (int i = 0; i < FRAMES; i++) begin
         age_in[i] = age_ff[i];
      end
      if (cmd.commit) begin
         if (final_ff) begin
            valid_in     = '0;
            valid_cnt_in = '0;
            fault_in     = '0;
            for (int i = 0; i < FRAMES; i++) begin
               age_in[i] = '0;
            end
         end else begin
            fault_in = fault_next;
            for (int i = 0; i < FRAMES; i++) begin
               if (IDX_W'(i) == slot) begin
                  age_in[i] = '0;
               end else if (valid_ff[i] && (CNT_W'(age_ff[i]) < old_rank)) begin
                  age_in[i] = age_ff[i] + IDX_W'(1);
               end
            end
            if (fill) begin
               valid_in[slot] = 1'b1;
               valid_cnt_in   = valid_cnt_ff + CNT_W'(1);
            end
         end
      end
   end

   // Result register: loaded at commit, emptied when the transaction is taken.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_hit_in     = rsp_hit_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_ev_in      = rsp_ev_ff;
      rsp_ev_page_in = rsp_ev_page_ff;
      rsp_fault_in   = rsp_fault_ff;
      if (cmd.commit) begin
         rsp_valid_in   = 1'b1;
         rsp_hit_in     = hit_found_ff;
         rsp_idx_in     = FRAME_INDEX_W'(slot);
         rsp_ev_in      = evict;
         rsp_ev_page_in = evict ? best_page_ff : '0;
         rsp_fault_in   = fault_next;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff     <= 1'b0;
         rd_idx_ff      <= '0;
         n_ff           <= CNT_W'(1);
         hit_found_ff   <= 1'b0;
         empty_found_ff <= 1'b0;
         valid_ff       <= '0;
         valid_cnt_ff   <= '0;
         fault_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < FRAMES; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         cmp_vld_ff     <= cmp_vld_in;
         rd_idx_ff      <= rd_idx_in;
         n_ff           <= n_in;
         hit_found_ff   <= hit_found_in;
         empty_found_ff <= empty_found_in;
         valid_ff       <= valid_in;
         valid_cnt_ff   <= valid_cnt_in;
         fault_ff       <= fault_in;
         rsp_valid_ff   <= rsp_valid_in;
         for (int i = 0; i < FRAMES; i++) begin
            age_ff[i] <= age_in[i];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      page_ff        <= page_in;
      final_ff       <= final_in;
      cmp_idx_ff     <= cmp_idx_in;
      hit_idx_ff     <= hit_idx_in;
      hit_age_ff     <= hit_age_in;
      empty_idx_ff   <= empty_idx_in;
      best_idx_ff    <= best_idx_in;
      best_age_ff    <= best_age_in;
      best_page_ff   <= best_page_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_ev_ff      <= rsp_ev_in;
      rsp_ev_page_ff <= rsp_ev_page_in;
      rsp_fault_ff   <= rsp_fault_in;
   end

   // Status and result ports.
   assign sts.scan_done = (rd_idx_ff == n_ff) && !cmp_vld_ff;
   assign sts.out_full  = rsp_valid_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_idx_ff;
   assign rsp_evicted_valid = rsp_ev_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_count   = rsp_fault_ff;

endmodule

### src/lru_page_replacement_core.sv
// Fully associative LRU page replacement core, top level with register port.
//
// Each request transaction carries one page reference and produces exactly one
// response transaction: hit or fault, the frame that holds the page afterwards,
// the evicted page if any, and the saturating fault total. Only the first
// frames_in_use frames (register at byte address 0, clamped to 1..FRAMES) are
// searched, filled or evicted. A reference with final_req set clears all frames
// and the fault total once its response has been formed. An item is handled
// in steps: it is accepted, the page memory is read for each frame in use, one
// frame per cycle, the last frame read is compared, the scan reports done, and
// the item is committed. The next request is taken while a response is still
// stalled at the output register; its commit then waits until that response
// has been taken.
`timescale 1ns / 1ps

module lru_page_replacement_core import lrupr_pkg::*; #(
   parameter int unsigned FRAMES    = 8,
   parameter int unsigned PAGE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // Request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [PAGE_BITS-1:0]     req_page,
   input  logic                     req_final_req,
   // Response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_hit,
   output logic [FRAME_INDEX_W-1:0] rsp_frame_index,
   output logic                     rsp_evicted_valid,
   output logic [PAGE_BITS-1:0]     rsp_evicted_page,
   output logic [FAULT_W-1:0]       rsp_fault_count,
   // Register port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [CSR_DATA_W-1:0]    csr_pwdata,
   output logic [CSR_DATA_W-1:0]    csr_prdata,
   output logic                     csr_pready
);

   logic [FIU_W-1:0] fiu_ff, fiu_in;
   logic             csr_write;
   dp_cmd_type       cmd;
   dp_sts_type       sts;

   // Register write in the access phase.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      fiu_in = fiu_ff;
      if (csr_write && (csr_paddr[2] == CSR_IDX_FRAMES_IN_USE)) begin
         fiu_in = csr_pwdata[FIU_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fiu_ff <= FIU_RESET;
      end else begin
         fiu_ff <= fiu_in;
      end
   end

   // Register read back.
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_FRAMES_IN_USE) begin
         csr_prdata = CSR_DATA_W'(fiu_ff);
      end
   end

   lrupr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lrupr_dp #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .frames_in_use     (fiu_ff),
      .req_page          (req_page),
      .req_final_req     (req_final_req),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_count   (rsp_fault_count)
   );

endmodule

### src/lrupr_checker.sv
// Port-level assertions for the LRU page replacement core, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lrupr_checker import lrupr_pkg::*; #(
   parameter int unsigned PAGE_BITS = 16
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic                     rsp_hit,
   input logic                     rsp_evicted_valid,
   input logic [PAGE_BITS-1:0]     rsp_evicted_page,
   input logic [FAULT_W-1:0]       rsp_fault_count
);

   // The core works on one transaction at a time after accepting it.
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "request taken while busy")

   // A stalled response stays offered.
   `ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid, "stalled response dropped")

   // A hit never evicts and reports no evicted page.
   `ASSERT_IMPLIES(a_hit_no_evict, clock, reset, rsp_valid && rsp_hit, !rsp_evicted_valid && (rsp_evicted_page == '0), "hit reported an eviction")

   // A fault is always counted in the reported total.
   `ASSERT_IMPLIES(a_fault_counted, clock, reset, rsp_valid && !rsp_hit, rsp_fault_count != '0, "fault not counted")

endmodule

bind lru_page_replacement_core lrupr_checker #(
   .PAGE_BITS (PAGE_BITS)
) u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_hit           (rsp_hit),
   .rsp_evicted_valid (rsp_evicted_valid),
   .rsp_evicted_page  (rsp_evicted_page),
   .rsp_fault_count   (rsp_fault_count)
);

### verif/tb_lru_page_replacement_core.sv
// Self-checking testbench for the LRU page replacement core with a mirrored frame predictor.
`timescale 1ns / 1ps

module tb_lru_page_replacement_core;
   import lrupr_pkg::*;

   localparam int unsigned FRAMES      = 8;
   localparam int unsigned PAGE_BITS   = 16;
   localparam int unsigned CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [PAGE_BITS-1:0] page;
      logic                 final_req;
   } page_ref_type;

   typedef struct packed {
      logic                     hit;
      logic [FRAME_INDEX_W-1:0] frame_index;
      logic                     evicted_valid;
      logic [PAGE_BITS-1:0]     evicted_page;
      logic [FAULT_W-1:0]       fault_count;
   } page_rsp_type;

   // Clock, reset and the block's inputs, all known from time zero.
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [PAGE_BITS-1:0]     req_page = '0;
   logic                     req_final_req = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_hit;
   logic [FRAME_INDEX_W-1:0] rsp_frame_index;
   logic                     rsp_evicted_valid;
   logic [PAGE_BITS-1:0]     rsp_evicted_page;
   logic [FAULT_W-1:0]       rsp_fault_count;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]    csr_paddr = '0;
   logic [CSR_DATA_W-1:0]    csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]    csr_prdata;
   logic                     csr_pready;

   // Mirror of the frame table and of the frames-in-use register.
   logic [PAGE_BITS-1:0]     mirror_page [FRAMES];
   logic                     mirror_valid [FRAMES];
   logic [2:0]               mirror_age [FRAMES];
   logic [FAULT_W-1:0]       mirror_faults;
   logic [FIU_W-1:0]         mirror_limit;

   page_ref_type             pending_ref_q [$];
   page_rsp_type             expected_rsp_q [$];

   logic [PAGE_BITS-1:0]     page_pool [16];
   int                       pool_size = 0;
   bit                       idle_on = 1'b0;
   int                       send_gap = 0;
   int                       stall_left = 0;
   int                       fail_cnt = 0;
   int                       cycle_cnt = 0;

   lru_page_replacement_core #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_page          (req_page),
      .req_final_req     (req_final_req),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_count   (rsp_fault_count),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #2 clock = ~clock;

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 88) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 10);
      else return $urandom_range(11, 40);
   endfunction

   // Make a frame the most recent; valid frames younger than its old rank age by one.
   function automatic void promote_frame(input int f, input int old_rank);
      for (int i = 0; i < FRAMES; i++) begin
         if (mirror_valid[i] && i != f && int'(mirror_age[i]) < old_rank)
            mirror_age[i] = mirror_age[i] + 3'd1;
      end
      mirror_age[f] = 3'd0;
   endfunction

   // Work out the response to one page reference and update the mirror.
   function automatic page_rsp_type predict_reference(input logic [PAGE_BITS-1:0] pg,
                                                      input logic fin);
      page_rsp_type r;
      int lim;
      int slot;
      int nvalid;
      r = '0;
      slot = -1;
      nvalid = 0;
      lim = int'(mirror_limit);
      if (lim < 1) lim = 1;
      if (lim > FRAMES) lim = FRAMES;

      // Search the frames in use; the lowest matching frame wins.
      for (int i = 0; i < lim; i++) begin
         if (slot < 0 && mirror_valid[i] && mirror_page[i] == pg) begin
            slot = i;
            r.hit = 1'b1;
         end
      end

      if (r.hit) begin
         promote_frame(slot, int'(mirror_age[slot]));
      end else begin
         for (int i = 0; i < FRAMES; i++)
            if (mirror_valid[i]) nvalid++;
         for (int i = 0; i < lim; i++)
            if (slot < 0 && !mirror_valid[i]) slot = i;
         if (slot >= 0) begin
            mirror_valid[slot] = 1'b1;
            mirror_page[slot] = pg;
            promote_frame(slot, nvalid);
         end else begin
            // Evict the oldest frame in use, lowest index on a tie.
            slot = 0;
            for (int i = 1; i < lim; i++)
               if (mirror_age[i] > mirror_age[slot]) slot = i;
            r.evicted_valid = 1'b1;
            r.evicted_page = mirror_page[slot];
            mirror_page[slot] = pg;
            promote_frame(slot, int'(mirror_age[slot]));
         end
         if (mirror_faults != '1) mirror_faults = mirror_faults + 1'b1;
      end

      r.frame_index = slot[FRAME_INDEX_W-1:0];
      r.fault_count = mirror_faults;

      // A final reference clears the frames and the fault total afterwards.
      if (fin) begin
         for (int i = 0; i < FRAMES; i++) begin
            mirror_valid[i] = 1'b0;
            mirror_age[i] = 3'd0;
         end
         mirror_faults = '0;
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_cnt++;
      end
   endfunction

   // Request driver: presents queued references and predicts each accepted one.
   always @(posedge clock) begin : drive_refs
      page_ref_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_rsp_q.push_back(predict_reference(req_page, req_final_req));
         if (req_valid && req_stall) begin
            // Hold the stalled transaction unchanged.
         end else if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap--;
         end else if (pending_ref_q.size() > 0) begin
            nxt = pending_ref_q.pop_front();
            req_valid <= 1'b1;
            req_page <= nxt.page;
            req_final_req <= nxt.final_req;
            send_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response monitor: random back-pressure and field-by-field comparison.
   always @(posedge clock) begin : check_rsp
      page_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual hit=%0b frame=%0d",
                        $time, rsp_hit, rsp_frame_index);
               fail_cnt++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("hit", 32'(want.hit), 32'(rsp_hit));
               check_field("frame_index", 32'(want.frame_index), 32'(rsp_frame_index));
               check_field("evicted_valid", 32'(want.evicted_valid),
                           32'(rsp_evicted_valid));
               check_field("evicted_page", 32'(want.evicted_page), 32'(rsp_evicted_page));
               check_field("fault_count", want.fault_count, rsp_fault_count);
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = pick_gap();
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic void queue_ref(input logic [PAGE_BITS-1:0] pg, input logic fin);
      page_ref_type item;
      item.page = pg;
      item.final_req = fin;
      pending_ref_q.push_back(item);
   endfunction

   // Random references drawn mostly from a small working set, renewed after each final one.
   task automatic queue_random_refs(input int count);
      logic [PAGE_BITS-1:0] pg;
      logic fin;
      for (int k = 0; k < count; k++) begin
         if (pool_size == 0) begin
            pool_size = $urandom_range(1, 12);
            for (int j = 0; j < pool_size; j++)
               page_pool[j] = PAGE_BITS'($urandom_range(0, 65535));
         end
         if ($urandom_range(0, 9) < 8)
            pg = page_pool[$urandom_range(0, pool_size - 1)];
         else
            pg = PAGE_BITS'($urandom_range(0, 65535));
         fin = ($urandom_range(0, 39) == 0);
         queue_ref(pg, fin);
         if (fin) pool_size = 0;
      end
   endtask

   // Wait until every transaction has been sent and answered.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_ref_q.size() != 0 || req_valid || expected_rsp_q.size() != 0);
   endtask

   // Register write: setup cycle, then access cycle until pready.
   task automatic write_frames_in_use(input logic [FIU_W-1:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {CSR_IDX_FRAMES_IN_USE, 2'b00};
      csr_pwdata <= CSR_DATA_W'(val);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      mirror_limit = val;
      @(negedge clock);
   endtask

   // Stimulus sequence and end of test.
   initial begin
      logic [FIU_W-1:0] limits [13];
      limits = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd5, 4'd2, 4'd8, 4'd6, 4'd4, 4'd7, 4'd12, 4'd3,
                 4'd8};
      for (int i = 0; i < FRAMES; i++) begin
         mirror_page[i] = '0;
         mirror_valid[i] = 1'b0;
         mirror_age[i] = 3'd0;
      end
      mirror_faults = '0;
      mirror_limit = FIU_RESET;
      idle_on = 1'b1;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Extreme pages, filling all frames, hits, evictions and a final reference.
      queue_ref(16'h0000, 1'b0);
      queue_ref(16'hFFFF, 1'b0);
      queue_ref(16'h0000, 1'b0);
      queue_ref(16'h5555, 1'b0);
      queue_ref(16'hAAAA, 1'b0);
      queue_ref(16'h8000, 1'b0);
      queue_ref(16'h0001, 1'b0);
      queue_ref(16'h7FFF, 1'b0);
      queue_ref(16'h1234, 1'b0);
      queue_ref(16'hFFFF, 1'b0);
      queue_ref(16'hBEEF, 1'b0);
      queue_ref(16'h0000, 1'b0);
      queue_ref(16'hCAFE, 1'b0);
      queue_ref(16'h5555, 1'b1);
      queue_ref(16'h0101, 1'b0);
      queue_ref(16'h0202, 1'b0);
      queue_ref(16'h0303, 1'b0);
      queue_ref(16'h0404, 1'b0);
      wait_drained();

      // Shrink to one frame mid-string so a page is held twice, then widen past the maximum.
      write_frames_in_use(4'd1);
      queue_ref(16'h0404, 1'b0);
      wait_drained();
      write_frames_in_use(4'd15);
      queue_ref(16'h0404, 1'b0);
      queue_ref(16'h0303, 1'b0);
      queue_ref(16'h0101, 1'b0);
      queue_ref(16'h0303, 1'b1);
      wait_drained();

      // A zero limit behaves as one frame.
      write_frames_in_use(4'd0);
      queue_random_refs(60);
      wait_drained();

      // Random phases over a range of limits, some with no idling at all.
      for (int k = 0; k < 13; k++) begin
         write_frames_in_use(limits[k]);
         idle_on = (k % 4 != 2);
         queue_random_refs(115);
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (fail_cnt == 0 && expected_rsp_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### files.f
+incdir+src
src/lrupr_pkg.sv
src/lrupr_ram.sv
src/lrupr_ctrl.sv
src/lrupr_dp.sv
src/lru_page_replacement_core.sv
src/lrupr_checker.sv
verif/tb_lru_page_replacement_core.sv
